// ----- rtl/rdir_pkg.sv -----
`timescale 1ns / 1ps
package rdir_pkg;

    // Field and register widths.
    localparam int AXIS_W    = 48;
    localparam int COMP_W    = 16;
    localparam int DIST_W    = 20;
    localparam int PSIZE_W   = 16;
    localparam int RES_W     = 13;
    localparam int PIX_W     = 12;
    localparam int OFF_IN_W  = 8;
    localparam int CFG_IDX_W = 3;

    // The combined vector needs this many bits above the sample fraction bits.
    localparam int COMB_EXTRA = 49;

    // Normalisation places the leading bit at position NORM_LEAD.
    localparam int NORM_LEAD = 29;
    localparam int NORM_W    = 30;
    localparam int SQ_W      = 60;
    localparam int N2_W      = 62;
    localparam int ROOT_W    = 31;
    localparam int SQ_REM_W  = 34;

    // Division and output scaling.
    localparam int UNIT_SHIFT = 14;
    localparam int UNIT_ONE   = 16384;
    localparam int QUOT_W     = 16;
    localparam int DIV_REM_W  = 32;
    localparam int DIV_NUM_W  = 45;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT = 3'd0,
        CFG_UP    = 3'd1,
        CFG_VIEW  = 3'd2,
        CFG_DIST  = 3'd3,
        CFG_PSIZE = 3'd4,
        CFG_HRES  = 3'd5,
        CFG_VRES  = 3'd6
    } t_cfg_index;

    // Sideband that travels with each item through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } t_ctl;

    // One signed Q1.14 component of a packed axis register.
    function automatic logic signed [COMP_W-1:0] axis_part(
        input logic [AXIS_W-1:0] axis,
        input int                k
    );
        return signed'(axis[k*COMP_W +: COMP_W]);
    endfunction

endpackage

// ----- rtl/pinhole_ray_direction_core.sv -----
`timescale 1ns / 1ps
// Pinhole camera primary ray generator. Each transfer on the input channel carries a pixel
// column, row and sub-pixel offset; one unit direction in signed Q1.14 comes back for
// each, in order, with zero_length set (and a zero direction) when the combined vector
// is null. The block is a fully pipelined datapath with a throughput of one item per cycle
// while the output is not stalled; the square root (31 stages) and the three-lane divider
// (17 stages) set the depth. A stall on the output freezes the whole pipeline. Camera axes,
// distance, pixel size and resolutions are written through the configuration channel, and
// only while no item is in flight: the user must ensure this, the block does not enforce it;
// resolutions above MAX_RESOLUTION are saturated on write.
module pinhole_ray_direction_core #(
    parameter int MAX_RESOLUTION       = 4096,
    parameter int SAMPLE_FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [rdir_pkg::PIX_W-1:0]            i_pixel_column,
    input  logic [rdir_pkg::PIX_W-1:0]            i_pixel_row,
    input  logic [rdir_pkg::OFF_IN_W-1:0]         i_sample_offset_x,
    input  logic [rdir_pkg::OFF_IN_W-1:0]         i_sample_offset_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rdir_pkg::COMP_W-1:0]    o_direction_x,
    output logic signed [rdir_pkg::COMP_W-1:0]    o_direction_y,
    output logic signed [rdir_pkg::COMP_W-1:0]    o_direction_z,
    output logic                                  o_zero_length,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rdir_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rdir_pkg::AXIS_W-1:0]           i_cfg_data
);
    localparam int C_W = SAMPLE_FRACTION_BITS + rdir_pkg::COMB_EXTRA;
    localparam int QW  = rdir_pkg::QUOT_W;

    logic [rdir_pkg::AXIS_W-1:0]  r_right, r_up, r_view;
    logic [rdir_pkg::DIST_W-1:0]  r_dist;
    logic [rdir_pkg::PSIZE_W-1:0] r_psize;
    logic [rdir_pkg::RES_W-1:0]   r_hres, r_vres;
    logic [rdir_pkg::RES_W-1:0]   n_res;

    logic                         en;
    logic                         front_valid;
    logic signed [C_W-1:0]        front_c [3];
    logic [rdir_pkg::NORM_W-1:0]  norm_mag [3];
    logic [rdir_pkg::N2_W-1:0]    norm_n2;
    rdir_pkg::t_ctl               norm_ctl;
    logic [rdir_pkg::ROOT_W-1:0]  sq_norm;
    logic [rdir_pkg::NORM_W-1:0]  sq_mag [3];
    rdir_pkg::t_ctl               sq_ctl;
    logic [QW-1:0]                div_q [3];
    rdir_pkg::t_ctl               div_ctl;
    logic [QW-1:0]                n_dir [3];

    logic                         r_out_valid;
    logic [QW-1:0]                r_dir [3];
    logic                         r_zero;

    // Configuration writes; resolution saturates at the maximum.
    assign o_cfg_ready = i_rst_n;
    assign n_res = (i_cfg_data[rdir_pkg::RES_W-1:0] > MAX_RESOLUTION)
                 ? rdir_pkg::RES_W'(MAX_RESOLUTION) : i_cfg_data[rdir_pkg::RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= rdir_pkg::AXIS_W'(48'h0000_0000_4000);
            r_up    <= rdir_pkg::AXIS_W'(48'h0000_4000_0000);
            r_view  <= rdir_pkg::AXIS_W'(48'hC000_0000_0000);
            r_dist  <= rdir_pkg::DIST_W'(8000);
            r_psize <= rdir_pkg::PSIZE_W'(256);
            r_hres  <= rdir_pkg::RES_W'(256);
            r_vres  <= rdir_pkg::RES_W'(256);
        end else if (i_cfg_valid) begin
            unique case (rdir_pkg::t_cfg_index'(i_cfg_index))
                rdir_pkg::CFG_RIGHT: r_right <= i_cfg_data;
                rdir_pkg::CFG_UP:    r_up    <= i_cfg_data;
                rdir_pkg::CFG_VIEW:  r_view  <= i_cfg_data;
                rdir_pkg::CFG_DIST:  r_dist  <= i_cfg_data[rdir_pkg::DIST_W-1:0];
                rdir_pkg::CFG_PSIZE: r_psize <= i_cfg_data[rdir_pkg::PSIZE_W-1:0];
                rdir_pkg::CFG_HRES:  r_hres  <= n_res;
                rdir_pkg::CFG_VRES:  r_vres  <= n_res;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being drained.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en && i_rst_n;

    rdir_front #(
        .SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_col   (i_pixel_column),
        .i_row   (i_pixel_row),
        .i_offx  (i_sample_offset_x),
        .i_offy  (i_sample_offset_y),
        .i_right (r_right),
        .i_up    (r_up),
        .i_view  (r_view),
        .i_dist  (r_dist),
        .i_psize (r_psize),
        .i_hres  (r_hres),
        .i_vres  (r_vres),
        .o_valid (front_valid),
        .o_c     (front_c)
    );

    rdir_norm #(
        .SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_c     (front_c),
        .o_mag   (norm_mag),
        .o_n2    (norm_n2),
        .o_ctl   (norm_ctl)
    );

    rdir_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_n2    (norm_n2),
        .i_mag   (norm_mag),
        .i_ctl   (norm_ctl),
        .o_norm  (sq_norm),
        .o_mag   (sq_mag),
        .o_ctl   (sq_ctl)
    );

    rdir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_norm  (sq_norm),
        .i_mag   (sq_mag),
        .i_ctl   (sq_ctl),
        .o_q     (div_q),
        .o_ctl   (div_ctl)
    );

    // Clamp to one, restore the sign, and force zero for a null vector.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_dir[k] = (div_q[k] > QW'(rdir_pkg::UNIT_ONE)) ? QW'(rdir_pkg::UNIT_ONE) : div_q[k];
            if (div_ctl.neg[k]) n_dir[k] = ~n_dir[k] + 1'b1;
            if (div_ctl.zero) n_dir[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir  <= n_dir;
            r_zero <= div_ctl.zero;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_direction_x = signed'(r_dir[0]);
    assign o_direction_y = signed'(r_dir[1]);
    assign o_direction_z = signed'(r_dir[2]);
    assign o_zero_length = r_zero;

endmodule

// ----- rtl/rdir_front.sv -----
`timescale 1ns / 1ps
module rdir_front #(
    parameter int SAMPLE_FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [rdir_pkg::PIX_W-1:0]            i_col,
    input  logic [rdir_pkg::PIX_W-1:0]            i_row,
    input  logic [rdir_pkg::OFF_IN_W-1:0]         i_offx,
    input  logic [rdir_pkg::OFF_IN_W-1:0]         i_offy,
    input  logic [rdir_pkg::AXIS_W-1:0]           i_right,
    input  logic [rdir_pkg::AXIS_W-1:0]           i_up,
    input  logic [rdir_pkg::AXIS_W-1:0]           i_view,
    input  logic [rdir_pkg::DIST_W-1:0]           i_dist,
    input  logic [rdir_pkg::PSIZE_W-1:0]          i_psize,
    input  logic [rdir_pkg::RES_W-1:0]            i_hres,
    input  logic [rdir_pkg::RES_W-1:0]            i_vres,
    output logic                                  o_valid,
    output logic signed [SAMPLE_FRACTION_BITS+rdir_pkg::COMB_EXTRA-1:0] o_c [3]
);
    localparam int F     = SAMPLE_FRACTION_BITS;
    localparam int OFF_W = (F < rdir_pkg::OFF_IN_W) ? F : rdir_pkg::OFF_IN_W;
    localparam int U_W   = F + 14;
    localparam int PX_W  = U_W + rdir_pkg::PSIZE_W + 1;
    localparam int P_W   = PX_W + rdir_pkg::COMP_W;
    localparam int VD_W  = rdir_pkg::COMP_W + rdir_pkg::DIST_W + 1;
    localparam int C_W   = F + rdir_pkg::COMB_EXTRA;

    logic [3:0]               r_vld;
    logic signed [U_W-1:0]    r_ux, r_uy;
    logic signed [PX_W-1:0]   r_px, r_py;
    logic signed [VD_W-1:0]   r_vd [3];
    logic signed [VD_W-1:0]   r_vd3 [3];
    logic signed [P_W-1:0]    r_pr [3];
    logic signed [P_W-1:0]    r_pu [3];
    logic signed [C_W-1:0]    r_c [3];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // View-plane offsets in units of 2^-F pixels; modular arithmetic is exact here.
            r_ux <= (U_W'(i_col) << F) - (U_W'(i_hres) << (F - 1)) + U_W'(i_offx[OFF_W-1:0]);
            r_uy <= (U_W'(i_row) << F) - (U_W'(i_vres) << (F - 1)) + U_W'(i_offy[OFF_W-1:0]);
            // Scale by pixel size, and form the distance term.
            r_px <= PX_W'(r_ux * $signed({1'b0, i_psize}));
            r_py <= PX_W'(r_uy * $signed({1'b0, i_psize}));
            for (int k = 0; k < 3; k++) begin
                r_vd[k] <= VD_W'(rdir_pkg::axis_part(i_view, k) * $signed({1'b0, i_dist}));
            end
            // Axis products.
            for (int k = 0; k < 3; k++) begin
                r_pr[k]  <= P_W'(rdir_pkg::axis_part(i_right, k) * r_px);
                r_pu[k]  <= P_W'(rdir_pkg::axis_part(i_up, k) * r_py);
                r_vd3[k] <= r_vd[k];
            end
            // Sum with the distance term aligned to the same fraction bits.
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= C_W'(r_pr[k]) + C_W'(r_pu[k]) + (C_W'(r_vd3[k]) <<< (F + 4));
            end
        end
    end

    assign o_valid = r_vld[3];
    assign o_c     = r_c;

endmodule

// ----- rtl/rdir_norm.sv -----
`timescale 1ns / 1ps
module rdir_norm #(
    parameter int SAMPLE_FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [SAMPLE_FRACTION_BITS+rdir_pkg::COMB_EXTRA-1:0] i_c [3],
    output logic [rdir_pkg::NORM_W-1:0]           o_mag [3],
    output logic [rdir_pkg::N2_W-1:0]             o_n2,
    output rdir_pkg::t_ctl                        o_ctl
);
    localparam int C_W  = SAMPLE_FRACTION_BITS + rdir_pkg::COMB_EXTRA;
    localparam int GRP  = 8;
    localparam int GP_W = $clog2(GRP);
    localparam int NG   = (C_W + GRP - 1) / GRP;
    localparam int P_W  = $clog2(NG * GRP);
    localparam int SH_W = C_W + rdir_pkg::NORM_LEAD;
    localparam int NW   = rdir_pkg::NORM_W;

    rdir_pkg::t_ctl       r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl, r6_ctl, r7_ctl;
    logic [C_W-1:0]       r1_mag [3];
    logic [C_W-1:0]       r2_mag [3];
    logic [C_W-1:0]       r3_mag [3];
    logic [C_W-1:0]       r4_mag [3];
    logic [C_W-1:0]       r2_or;
    logic [NG-1:0]        r3_nz;
    logic [GP_W-1:0]      r3_pos [NG];
    logic [P_W-1:0]       r4_p;
    logic [NW-1:0]        r5_mag [3];
    logic [NW-1:0]        r6_mag [3];
    logic [NW-1:0]        r7_mag [3];
    logic [rdir_pkg::SQ_W-1:0] r6_sq [3];
    logic [rdir_pkg::N2_W-1:0] r7_n2;

    logic [NG*GRP-1:0]    pad_or;
    logic [NG-1:0]        n_nz;
    logic [GP_W-1:0]      n_pos [NG];
    logic [P_W-1:0]       n_p;
    logic [SH_W-1:0]      wide [3];
    logic [2:0]           n_neg;

    // Group flags and leading bit in each group of the OR of the magnitudes.
    always_comb begin
        pad_or = (NG * GRP)'(r2_or);
        for (int g = 0; g < NG; g++) begin
            n_nz[g]  = |pad_or[g*GRP +: GRP];
            n_pos[g] = '0;
            for (int b = 0; b < GRP; b++) begin
                if (pad_or[g*GRP + b]) n_pos[g] = GP_W'(b);
            end
        end
    end

    // Highest non-empty group gives the leading bit position.
    always_comb begin
        n_p = '0;
        for (int g = 0; g < NG; g++) begin
            if (r3_nz[g]) n_p = P_W'(g * GRP) + P_W'(r3_pos[g]);
        end
    end

    // Shift so the leading bit lands at NORM_LEAD; right shifts truncate.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wide[k]  = {r4_mag[k], {rdir_pkg::NORM_LEAD{1'b0}}} >> r4_p;
            n_neg[k] = i_c[k][C_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0; r2_ctl <= '0; r3_ctl <= '0; r4_ctl <= '0;
            r5_ctl <= '0; r6_ctl <= '0; r7_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= '{valid: i_valid, zero: 1'b0, neg: n_neg};
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= '{valid: r3_ctl.valid, zero: ~|r3_nz, neg: r3_ctl.neg};
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
            r7_ctl <= r6_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_mag[k] <= i_c[k][C_W-1] ? C_W'(~i_c[k] + 1'b1) : C_W'(i_c[k]);
                r2_mag[k] <= r1_mag[k];
                r3_mag[k] <= r2_mag[k];
                r4_mag[k] <= r3_mag[k];
                r5_mag[k] <= wide[k][NW-1:0];
                r6_mag[k] <= r5_mag[k];
                r6_sq[k]  <= r5_mag[k] * r5_mag[k];
                r7_mag[k] <= r6_mag[k];
            end
            r2_or  <= r1_mag[0] | r1_mag[1] | r1_mag[2];
            r3_nz  <= n_nz;
            r3_pos <= n_pos;
            r4_p   <= n_p;
            r7_n2  <= rdir_pkg::N2_W'(r6_sq[0]) + rdir_pkg::N2_W'(r6_sq[1])
                    + rdir_pkg::N2_W'(r6_sq[2]);
        end
    end

    assign o_mag = r7_mag;
    assign o_n2  = r7_n2;
    assign o_ctl = r7_ctl;

endmodule

// ----- rtl/rdir_sqrt.sv -----
`timescale 1ns / 1ps
module rdir_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rdir_pkg::N2_W-1:0]     i_n2,
    input  logic [rdir_pkg::NORM_W-1:0]   i_mag [3],
    input  rdir_pkg::t_ctl                i_ctl,
    output logic [rdir_pkg::ROOT_W-1:0]   o_norm,
    output logic [rdir_pkg::NORM_W-1:0]   o_mag [3],
    output rdir_pkg::t_ctl                o_ctl
);
    localparam int NS  = rdir_pkg::ROOT_W;
    localparam int RW  = rdir_pkg::SQ_REM_W;
    localparam int N2W = rdir_pkg::N2_W;

    logic [RW-1:0]                 s_rem [NS];
    logic [NS-1:0]                 s_root [NS];
    logic [N2W-1:0]                s_n [NS];
    logic [rdir_pkg::NORM_W-1:0]   s_mag [NS][3];
    rdir_pkg::t_ctl                s_ctl [NS];

    logic [RW-1:0]                 r_rem [NS];
    logic [NS-1:0]                 r_root [NS];
    logic [N2W-1:0]                r_n [NS];
    logic [rdir_pkg::NORM_W-1:0]   r_mag [NS][3];
    rdir_pkg::t_ctl                r_ctl [NS];

    // One result bit per stage, two radicand bits consumed in each.
    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [RW-1:0] pre, trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign s_rem[i]  = '0;
            assign s_root[i] = '0;
            assign s_n[i]    = i_n2;
            assign s_mag[i]  = i_mag;
            assign s_ctl[i]  = i_ctl;
        end else begin : g_next
            assign s_rem[i]  = r_rem[i-1];
            assign s_root[i] = r_root[i-1];
            assign s_n[i]    = r_n[i-1];
            assign s_mag[i]  = r_mag[i-1];
            assign s_ctl[i]  = r_ctl[i-1];
        end

        assign pre   = {s_rem[i][RW-3:0], s_n[i][N2W-1 -: 2]};
        assign trial = {1'b0, s_root[i], 2'b01};
        assign ge    = (pre >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else if (i_en) begin
                r_ctl[i] <= s_ctl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? (pre - trial) : pre;
                r_root[i] <= {s_root[i][NS-2:0], ge};
                r_n[i]    <= s_n[i] << 2;
                r_mag[i]  <= s_mag[i];
            end
        end
    end

    assign o_norm = r_root[NS-1];
    assign o_mag  = r_mag[NS-1];
    assign o_ctl  = r_ctl[NS-1];

endmodule

// ----- rtl/rdir_div.sv -----
`timescale 1ns / 1ps
module rdir_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rdir_pkg::ROOT_W-1:0]   i_norm,
    input  logic [rdir_pkg::NORM_W-1:0]   i_mag [3],
    input  rdir_pkg::t_ctl                i_ctl,
    output logic [rdir_pkg::QUOT_W-1:0]   o_q [3],
    output rdir_pkg::t_ctl                o_ctl
);
    localparam int NS = rdir_pkg::QUOT_W;
    localparam int RW = rdir_pkg::DIV_REM_W;
    localparam int NW = rdir_pkg::DIV_NUM_W;
    localparam int DW = rdir_pkg::ROOT_W;

    logic [NW-1:0]  r0_num [3];
    logic [DW-1:0]  r0_d;
    rdir_pkg::t_ctl r0_ctl;

    logic [RW-1:0]  s_rem [NS][3];
    logic [NW-1:0]  s_num [NS][3];
    logic [NS-1:0]  s_q   [NS][3];
    logic [DW-1:0]  s_d   [NS];
    rdir_pkg::t_ctl s_ctl [NS];

    logic [RW-1:0]  r_rem [NS][3];
    logic [NW-1:0]  r_num [NS][3];
    logic [NS-1:0]  r_q   [NS][3];
    logic [DW-1:0]  r_d   [NS];
    rdir_pkg::t_ctl r_ctl [NS];

    // Rounded numerator: magnitude scaled to Q1.14 plus half the norm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else if (i_en) begin
            r0_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r0_num[k] <= (NW'(i_mag[k]) << rdir_pkg::UNIT_SHIFT) + NW'(i_norm >> 1);
            end
            r0_d <= i_norm;
        end
    end

    // Restoring division, one quotient bit per stage in each of three lanes.
    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [RW-1:0] pre [3];
        logic [2:0]    ge;

        if (i == 0) begin : g_first
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign s_rem[i][k] = RW'(r0_num[k][NW-1:NS]);
                assign s_num[i][k] = r0_num[k];
                assign s_q[i][k]   = '0;
            end
            assign s_d[i]   = r0_d;
            assign s_ctl[i] = r0_ctl;
        end else begin : g_next
            assign s_rem[i] = r_rem[i-1];
            assign s_num[i] = r_num[i-1];
            assign s_q[i]   = r_q[i-1];
            assign s_d[i]   = r_d[i-1];
            assign s_ctl[i] = r_ctl[i-1];
        end

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                pre[k] = {s_rem[i][k][RW-2:0], s_num[i][k][NS-1-i]};
                ge[k]  = (pre[k] >= RW'(s_d[i]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else if (i_en) begin
                r_ctl[i] <= s_ctl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[i][k] <= ge[k] ? (pre[k] - RW'(s_d[i])) : pre[k];
                    r_q[i][k]   <= {s_q[i][k][NS-2:0], ge[k]};
                end
                r_num[i] <= s_num[i];
                r_d[i]   <= s_d[i];
            end
        end
    end

    assign o_q   = r_q[NS-1];
    assign o_ctl = r_ctl[NS-1];

endmodule
